// ----- rtl/uht_pkg.sv -----
// Shared types and constants of the IPv4 hash table unit.
`default_nettype none

package uht_pkg;

  localparam int BUCKETS   = 257;
  localparam int BUCKET_W  = 9;
  localparam int ADDR_W    = 32;
  localparam int WEIGHT_W  = 9;
  localparam int OCTETS    = 4;
  localparam int PROD_W    = 17;
  localparam int ACC_W     = 20;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int REG_IDX_W = 2;
  localparam int COUNT_W   = 32;
  localparam int LONG_W    = 4;

  localparam logic [BUCKET_W-1:0] HASH_MODULUS = 9'd257;

  // Operation codes; the unused code behaves as a lookup.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_FOUR  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_THREE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_TWO   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_ONE   = 2'd3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_FOUR_RST  = 9'd10;
  localparam logic [WEIGHT_W-1:0] WEIGHT_THREE_RST = 9'd89;
  localparam logic [WEIGHT_W-1:0] WEIGHT_TWO_RST   = 9'd210;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE_RST   = 9'd162;

  typedef logic [WEIGHT_W-1:0] weight_t;

  typedef struct packed {
    logic                done;
    logic [BUCKET_W-1:0] bucket;
  } hash_res_t;

  typedef enum logic [1:0] {
    H_IDLE,
    H_MUL,
    H_LAST,
    H_MOD
  } hash_state_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_WALK,
    S_WB
  } top_state_e;

endpackage

`default_nettype wire

// ----- rtl/uht_hash.sv -----
// Iterative weighted octet sum with a shared multiplier and mod 257 fold.
`default_nettype none

module uht_hash
  import uht_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire weight_t           weight_i [OCTETS],
  output hash_res_t              res_o
);

  hash_state_e         state_q, state_d;
  logic [1:0]          oct_q;
  logic [PROD_W-1:0]   prod_q;
  logic [ACC_W-1:0]    acc_q;
  logic [BUCKET_W-1:0] bucket_q;
  logic                done_q;
  logic [PROD_W-1:0]   prod;
  logic [7:0]          octet;

  // 256 is -1 mod 257: fold x = h1*65536 + h0*256 + l into l - h0 + h1.
  function automatic logic [BUCKET_W-1:0] mod257(input logic [ACC_W-1:0] x);
    logic [9:0] t;
    t = 10'(x[7:0]) + 10'(x[19:16]) + 10'(HASH_MODULUS) - 10'(x[15:8]);
    if (t >= 10'(2 * 257)) begin
      t = t - 10'(2 * 257);
    end else if (t >= 10'(HASH_MODULUS)) begin
      t = t - 10'(HASH_MODULUS);
    end
    return t[BUCKET_W-1:0];
  endfunction

  assign octet = addr_i[8*oct_q +: 8];
  assign prod  = PROD_W'(weight_i[oct_q]) * PROD_W'(octet);

  always_comb begin
    state_d = state_q;
    case (state_q)
      H_IDLE:  if (start_i) state_d = H_MUL;
      H_MUL:   if (oct_q == 2'd3) state_d = H_LAST;
      H_LAST:  state_d = H_MOD;
      H_MOD:   state_d = H_IDLE;
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      oct_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == H_MOD);
      if (state_q == H_IDLE) begin
        oct_q <= '0;
      end else if (state_q == H_MUL) begin
        oct_q <= oct_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      H_IDLE: acc_q <= '0;
      H_MUL: begin
        prod_q <= prod;
        if (oct_q != 2'd0) acc_q <= acc_q + ACC_W'(prod_q);
      end
      H_LAST:  acc_q <= acc_q + ACC_W'(prod_q);
      H_MOD:   bucket_q <= mod257(acc_q);
      default: ;
    endcase
  end

  assign res_o.done   = done_q;
  assign res_o.bucket = bucket_q;

endmodule

`default_nettype wire

// ----- rtl/uht_entry_ram.sv -----
// Entry store: one write port and one registered read port.
`default_nettype none

module uht_entry_ram
  import uht_pkg::*;
#(
  parameter int DEPTH = 2056,
  parameter int AW    = 12
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [ADDR_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [ADDR_W-1:0] rdata_o
);

  logic [ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/ipv4_universal_hash_table_unit.sv -----
// Top level of the IPv4 hash table unit: sequencer, chain lengths, statistics.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  command   | start_i, busy_o            | kind_i, ip_address_i
//  result    | done_o (one-cycle strobe)  | status_o, bucket_o, counts and chain stats
//  config    | cfg_valid_i, cfg_ready_o   | cfg_index_i, cfg_data_i
//
// The result strobe follows accept after hashing on the shared multiplier, the chain
// length read, a walk over the bucket's entries on the entry RAM read port and a
// write-back. busy_o drops in the strobe cycle, so the next command may be taken
// there. After reset a clearing pass zeroes the chain lengths of all 257 buckets
// with busy_o high; configuration writes are taken at any time. No receiver stall.
`default_nettype none

module ipv4_universal_hash_table_unit
  import uht_pkg::*;
#(
  parameter int CHAIN_DEPTH = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [KIND_W-1:0]    kind_i,
  input  wire logic [ADDR_W-1:0]    ip_address_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic      [STATUS_W-1:0]  status_o,
  output logic      [BUCKET_W-1:0]  bucket_o,
  output logic      [COUNT_W-1:0]   insert_count_o,
  output logic      [COUNT_W-1:0]   delete_count_o,
  output logic      [LONG_W-1:0]    longest_chain_o,
  output logic      [BUCKET_W-1:0]  longest_bucket_o,
  output logic      [BUCKET_W-1:0]  empty_buckets_o,
  output logic      [BUCKET_W-1:0]  single_buckets_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [REG_IDX_W-1:0] cfg_index_i,
  input  wire logic [WEIGHT_W-1:0]  cfg_data_i
);

  localparam int ENTRIES = BUCKETS * CHAIN_DEPTH;
  localparam int EAW     = $clog2(ENTRIES);
  localparam int LEN_W   = $clog2(CHAIN_DEPTH + 1);

  top_state_e          state_q, state_d;
  weight_t             weight_q [OCTETS];
  logic [KIND_W-1:0]   kind_q;
  logic [ADDR_W-1:0]   addr_q;
  hash_res_t           hres;
  logic [BUCKET_W-1:0] clr_q;

  logic [LEN_W-1:0]    len_mem [BUCKETS];
  logic [LEN_W-1:0]    len_rd_q;
  logic                len_re, len_we;
  logic [BUCKET_W-1:0] len_waddr;
  logic [LEN_W-1:0]    len_wdata;

  logic [LEN_W-1:0]    idx_q, pend_idx_q, slot_q;
  logic                pend_q, found_q;
  logic [ADDR_W-1:0]   last_q;
  logic                issue;

  logic [EAW-1:0]      base;
  logic                ram_we;
  logic [EAW-1:0]      ram_waddr;
  logic [ADDR_W-1:0]   ram_wdata, ram_rdata;

  logic [STATUS_W-1:0] status_q, status_d;
  logic                done_q;
  logic                ins_ok, rem_ok;
  logic [LEN_W-1:0]    new_len;
  logic [COUNT_W-1:0]  ins_cnt_q, del_cnt_q;
  logic [LONG_W-1:0]   longest_q;
  logic [BUCKET_W-1:0] longest_idx_q, empty_q, single_q;
  logic                accept;

  assign accept = start_i && !busy_o;

  uht_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .addr_i   (addr_q),
    .weight_i (weight_q),
    .res_o    (hres)
  );

  assign base  = EAW'(32'(hres.bucket) * CHAIN_DEPTH);
  assign issue = (state_q == S_WALK) && (idx_q < len_rd_q);

  uht_entry_ram #(
    .DEPTH (ENTRIES),
    .AW    (EAW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (base + EAW'(idx_q)),
    .rdata_o (ram_rdata)
  );

  // Next state and write-back decisions.
  always_comb begin
    state_d   = state_q;
    status_d  = ST_OK;
    ins_ok    = 1'b0;
    rem_ok    = 1'b0;
    new_len   = len_rd_q;
    len_re    = 1'b0;
    len_we    = 1'b0;
    len_waddr = hres.bucket;
    len_wdata = '0;
    ram_we    = 1'b0;
    ram_waddr = base + EAW'(len_rd_q);
    ram_wdata = addr_q;
    case (kind_q)
      KIND_INSERT: begin
        if (found_q) begin
          status_d = ST_DUP;
        end else if (len_rd_q >= LEN_W'(CHAIN_DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          ins_ok  = 1'b1;
          new_len = len_rd_q + LEN_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (!found_q) begin
          status_d = ST_ABSENT;
        end else begin
          rem_ok  = 1'b1;
          new_len = len_rd_q - LEN_W'(1);
        end
      end
      default: status_d = found_q ? ST_OK : ST_ABSENT;
    endcase
    case (state_q)
      S_CLEAR: begin
        len_we    = 1'b1;
        len_waddr = clr_q;
        if (clr_q == BUCKET_W'(BUCKETS - 1)) state_d = S_IDLE;
      end
      S_IDLE: if (accept) state_d = S_HASH;
      S_HASH: begin
        if (hres.done) begin
          len_re  = 1'b1;
          state_d = S_WALK;
        end
      end
      S_WALK: if (!issue && !pend_q) state_d = S_WB;
      S_WB: begin
        len_we    = ins_ok || rem_ok;
        len_wdata = new_len;
        ram_we    = ins_ok || rem_ok;
        // Removal moves the bucket's last entry into the freed slot.
        if (rem_ok) begin
          ram_waddr = base + EAW'(slot_q);
          ram_wdata = last_q;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (len_re) len_rd_q <= len_mem[hres.bucket];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      done_q        <= 1'b0;
      ins_cnt_q     <= '0;
      del_cnt_q     <= '0;
      longest_q     <= '0;
      longest_idx_q <= '0;
      empty_q       <= BUCKET_W'(BUCKETS);
      single_q      <= '0;
      idx_q         <= '0;
      pend_q        <= 1'b0;
      found_q       <= 1'b0;
      weight_q[0]   <= WEIGHT_FOUR_RST;
      weight_q[1]   <= WEIGHT_THREE_RST;
      weight_q[2]   <= WEIGHT_TWO_RST;
      weight_q[3]   <= WEIGHT_ONE_RST;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_WB);
      if (state_q == S_CLEAR) clr_q <= clr_q + BUCKET_W'(1);

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_WEIGHT_FOUR:  weight_q[0] <= cfg_data_i;
          REG_WEIGHT_THREE: weight_q[1] <= cfg_data_i;
          REG_WEIGHT_TWO:   weight_q[2] <= cfg_data_i;
          REG_WEIGHT_ONE:   weight_q[3] <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == S_HASH) begin
        idx_q   <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
      end else if (state_q == S_WALK) begin
        pend_q <= issue;
        if (issue) idx_q <= idx_q + LEN_W'(1);
        if (pend_q && (ram_rdata == addr_q)) found_q <= 1'b1;
      end

      if (state_q == S_WB) begin
        if (ins_ok) begin
          ins_cnt_q <= ins_cnt_q + COUNT_W'(1);
          if (len_rd_q == '0) begin
            empty_q  <= empty_q - BUCKET_W'(1);
            single_q <= single_q + BUCKET_W'(1);
          end else if (len_rd_q == LEN_W'(1)) begin
            single_q <= single_q - BUCKET_W'(1);
          end
          // Longest mark only rises; the higher bucket wins a tie.
          if (LONG_W'(new_len) > longest_q) begin
            longest_q     <= LONG_W'(new_len);
            longest_idx_q <= hres.bucket;
          end else if ((LONG_W'(new_len) == longest_q) && (hres.bucket > longest_idx_q)) begin
            longest_idx_q <= hres.bucket;
          end
        end
        if (rem_ok) begin
          del_cnt_q <= del_cnt_q + COUNT_W'(1);
          if (len_rd_q == LEN_W'(1)) begin
            single_q <= single_q - BUCKET_W'(1);
            empty_q  <= empty_q + BUCKET_W'(1);
          end else if (len_rd_q == LEN_W'(2)) begin
            single_q <= single_q + BUCKET_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      addr_q <= ip_address_i;
    end
    if ((state_q == S_WALK) && pend_q) begin
      last_q <= ram_rdata;
      if (ram_rdata == addr_q) slot_q <= pend_idx_q;
    end
    if (state_q == S_WALK) pend_idx_q <= idx_q;
    if (state_q == S_WB) status_q <= status_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign bucket_o         = hres.bucket;
  assign insert_count_o   = ins_cnt_q;
  assign delete_count_o   = del_cnt_q;
  assign longest_chain_o  = longest_q;
  assign longest_bucket_o = longest_idx_q;
  assign empty_buckets_o  = empty_q;
  assign single_buckets_o = single_q;
  assign cfg_ready_o      = 1'b1;

endmodule

`default_nettype wire

// ----- rtl/uht_checker.sv -----
// Port-level assertions for the IPv4 hash table unit, bound to the top level.
`default_nettype none

module uht_checker
  import uht_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire logic                done_o,
  input wire logic [COUNT_W-1:0]  insert_count_o,
  input wire logic [COUNT_W-1:0]  delete_count_o,
  input wire logic [BUCKET_W-1:0] empty_buckets_o,
  input wire logic [BUCKET_W-1:0] single_buckets_o
);

  // An accepted transaction keeps the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("unit not busy after accepting a transaction");

  // A result never comes back to back.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // Statistics move only with a delivered result.
  a_counts_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$stable(insert_count_o) || !$stable(delete_count_o)) |-> done_o)
    else $error("counter changed without a result");

  // Empty and single-entry buckets together never exceed the bucket count.
  a_bucket_census: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (10'(empty_buckets_o) + 10'(single_buckets_o)) <= 10'(BUCKETS))
    else $error("bucket census exceeds bucket count");

endmodule

bind ipv4_universal_hash_table_unit uht_checker u_uht_checker (.*);

`default_nettype wire

// ----- sim/tb_ipv4_universal_hash_table_unit.sv -----
// Self-checking testbench of the IPv4 hash table unit with a shadow table predictor.
module tb_ipv4_universal_hash_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import uht_pkg::*;

  localparam int DEPTH          = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int POOL_SIZE      = 48;
  // The spare operation code behaves as a lookup.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [BUCKET_W-1:0] bucket;
    logic [COUNT_W-1:0]  inserts;
    logic [COUNT_W-1:0]  deletes;
    logic [LONG_W-1:0]   longest;
    logic [BUCKET_W-1:0] longest_bucket;
    logic [BUCKET_W-1:0] empty;
    logic [BUCKET_W-1:0] single;
  } table_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic [KIND_W-1:0]    kind_i;
  logic [ADDR_W-1:0]    ip_address_i;
  logic                 busy_o;
  logic                 done_o;
  logic [STATUS_W-1:0]  status_o;
  logic [BUCKET_W-1:0]  bucket_o;
  logic [COUNT_W-1:0]   insert_count_o;
  logic [COUNT_W-1:0]   delete_count_o;
  logic [LONG_W-1:0]    longest_chain_o;
  logic [BUCKET_W-1:0]  longest_bucket_o;
  logic [BUCKET_W-1:0]  empty_buckets_o;
  logic [BUCKET_W-1:0]  single_buckets_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i;
  logic [WEIGHT_W-1:0]  cfg_data_i;

  // Shadow copy of the table and its statistics.
  weight_t             hash_weight[4];
  logic [ADDR_W-1:0]   table_addrs[BUCKETS][DEPTH];
  int                  chain_len[BUCKETS];
  logic [COUNT_W-1:0]  insert_total;
  logic [COUNT_W-1:0]  delete_total;
  int                  peak_len;
  logic [BUCKET_W-1:0] peak_bucket;
  int                  empty_total;
  int                  single_total;

  table_result_t     pending_results[$];
  logic [ADDR_W-1:0] recent_addrs[$];
  int                mismatches;
  int                quiet_cycles;
  int                burst_left;

  ipv4_universal_hash_table_unit #(
    .CHAIN_DEPTH(DEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .kind_i          (kind_i),
    .ip_address_i    (ip_address_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .status_o        (status_o),
    .bucket_o        (bucket_o),
    .insert_count_o  (insert_count_o),
    .delete_count_o  (delete_count_o),
    .longest_chain_o (longest_chain_o),
    .longest_bucket_o(longest_bucket_o),
    .empty_buckets_o (empty_buckets_o),
    .single_buckets_o(single_buckets_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [BUCKET_W-1:0] hash_bucket_of(logic [ADDR_W-1:0] addr);
    logic [31:0] sum;
    sum = hash_weight[REG_WEIGHT_FOUR] * addr[7:0] + hash_weight[REG_WEIGHT_THREE] * addr[15:8]
        + hash_weight[REG_WEIGHT_TWO] * addr[23:16] + hash_weight[REG_WEIGHT_ONE] * addr[31:24];
    return BUCKET_W'(sum % HASH_MODULUS);
  endfunction

  // Apply one operation to the shadow table and return the result it must produce.
  function automatic table_result_t hash_table_apply(logic [KIND_W-1:0] kind,
                                                    logic [ADDR_W-1:0] addr);
    table_result_t       res;
    logic [BUCKET_W-1:0] b;
    int                  len;
    int                  slot;
    b    = hash_bucket_of(addr);
    len  = chain_len[b];
    slot = -1;
    for (int i = 0; i < len; i++)
      if (slot < 0 && table_addrs[b][i] == addr) slot = i;
    res.status = ST_OK;
    if (kind == KIND_INSERT) begin
      if (slot >= 0) begin
        res.status = ST_DUP;
      end else if (len >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        table_addrs[b][len] = addr;
        if (len == 0) begin
          empty_total--;
          single_total++;
        end else if (len == 1) begin
          single_total--;
        end
        len++;
        chain_len[b] = len;
        insert_total++;
        // The mark only rises; on a tie the higher bucket wins.
        if (len > peak_len || (len == peak_len && b > peak_bucket)) begin
          peak_len    = len;
          peak_bucket = b;
        end
      end
    end else if (kind == KIND_REMOVE) begin
      if (slot < 0) begin
        res.status = ST_ABSENT;
      end else begin
        // Move the last entry into the freed slot.
        table_addrs[b][slot] = table_addrs[b][len-1];
        if (len == 1) begin
          single_total--;
          empty_total++;
        end else if (len == 2) begin
          single_total++;
        end
        chain_len[b] = len - 1;
        delete_total++;
      end
    end else if (slot < 0) begin
      res.status = ST_ABSENT;
    end
    res.bucket         = b;
    res.inserts        = insert_total;
    res.deletes        = delete_total;
    res.longest        = LONG_W'(peak_len);
    res.longest_bucket = peak_bucket;
    res.empty          = BUCKET_W'(empty_total);
    res.single         = BUCKET_W'(single_total);
    return res;
  endfunction

  // Octets lean toward their extremes.
  function automatic logic [ADDR_W-1:0] random_address();
    logic [ADDR_W-1:0] a;
    for (int i = 0; i < OCTETS; i++)
      case ($urandom_range(0, 3))
        0:       a[i*8 +: 8] = 8'h00;
        1:       a[i*8 +: 8] = 8'hFF;
        default: a[i*8 +: 8] = 8'($urandom);
      endcase
    return a;
  endfunction

  // Search for an address that lands in the given bucket under the current weights.
  function automatic logic [ADDR_W-1:0] address_in_bucket(logic [BUCKET_W-1:0] target);
    logic [ADDR_W-1:0] a;
    for (int tries = 0; tries < 4000; tries++) begin
      a = $urandom;
      if (hash_bucket_of(a) == target) return a;
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic send_op(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr);
    @(negedge clk_i);
    start_i      <= 1'b1;
    kind_i       <= kind;
    ip_address_i <= addr;
    do @(posedge clk_i); while (busy_o);
    pending_results = {pending_results, hash_table_apply(kind, addr)};
  endtask

  task automatic hold_start_low(int cycles);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Burst pacing of the command side.
  task automatic pace_sender(bit bursty);
    if (bursty) begin
      if (burst_left == 0) begin
        hold_start_low($urandom_range(1, 24));
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, weight_t value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    hash_weight[idx] = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_weights(weight_t w_four, weight_t w_three, weight_t w_two, weight_t w_one);
    wait_until_drained();
    write_reg(REG_WEIGHT_FOUR, w_four);
    write_reg(REG_WEIGHT_THREE, w_three);
    write_reg(REG_WEIGHT_TWO, w_two);
    write_reg(REG_WEIGHT_ONE, w_one);
  endtask

  // Every operation, duplicates, absent entries and the spare code under reset weights.
  task automatic test_basic_ops();
    send_op(KIND_LOOKUP, 32'h0000_0000);
    send_op(KIND_REMOVE, 32'h0000_0000);
    send_op(KIND_INSERT, 32'h0000_0000);
    send_op(KIND_INSERT, 32'h0000_0000);
    send_op(KIND_INSERT, 32'hFFFF_FFFF);
    send_op(KIND_LOOKUP, 32'hFFFF_FFFF);
    send_op(KIND_SPARE, 32'hFFFF_FFFF);
    send_op(KIND_SPARE, 32'hC0A8_0101);
    send_op(KIND_REMOVE, 32'h0000_0000);
    send_op(KIND_LOOKUP, 32'h0000_0000);
    send_op(KIND_INSERT, 32'hC0A8_0101);
    send_op(KIND_REMOVE, 32'hFFFF_FFFF);
  endtask

  // Zero weights send every address to bucket zero, so the bucket fills up.
  task automatic test_full_bucket();
    load_weights('0, '0, '0, '0);
    for (int i = 0; i <= DEPTH; i++)
      send_op(KIND_INSERT, 32'h0A00_0001 + ADDR_W'(i));
    send_op(KIND_INSERT, 32'h0A00_0003);
    send_op(KIND_REMOVE, 32'h0A00_0002);
    send_op(KIND_LOOKUP, 32'h0A00_0002);
    send_op(KIND_INSERT, 32'h0A00_00FF);
    // Weights beyond the modulus are used as given.
    load_weights('1, '1, '1, '1);
    send_op(KIND_LOOKUP, 32'hFFFF_FFFF);
  endtask

  task automatic run_random_phase(int items, bit bursty);
    logic [BUCKET_W-1:0] hot_buckets[3];
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   addr;
    int                  pick;
    foreach (hot_buckets[i]) hot_buckets[i] = BUCKET_W'($urandom_range(0, BUCKETS - 1));
    burst_left = 0;
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      kind = KIND_INSERT;
      else if (pick < 70) kind = KIND_REMOVE;
      else if (pick < 95) kind = KIND_LOOKUP;
      else                kind = KIND_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 40 && recent_addrs.size() > 0)
        addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
      else if (pick < 75)
        addr = address_in_bucket(hot_buckets[$urandom_range(0, 2)]);
      else
        addr = random_address();
      if (kind == KIND_INSERT) begin
        recent_addrs = {recent_addrs, addr};
        if (recent_addrs.size() > POOL_SIZE) void'(recent_addrs.pop_front());
      end
      send_op(kind, addr);
      // Now and then let the table go idle before the next command.
      if ($urandom_range(0, 49) == 0) wait_until_drained();
      pace_sender(bursty);
    end
  endtask

  task automatic test_random_traffic();
    load_weights(WEIGHT_FOUR_RST, WEIGHT_THREE_RST, WEIGHT_TWO_RST, WEIGHT_ONE_RST);
    run_random_phase(250, 1'b1);
    load_weights(9'd256, 9'd256, 9'd256, 9'd256);
    run_random_phase(130, 1'b0);
    load_weights(9'd511, 9'd0, 9'd300, 9'd1);
    run_random_phase(130, 1'b1);
    load_weights(weight_t'($urandom), weight_t'($urandom), weight_t'($urandom),
                 weight_t'($urandom));
    run_random_phase(130, 1'b1);
  endtask

  always @(posedge clk_i) begin : result_check
    table_result_t got;
    table_result_t want;
    if (rst_ni && done_o) begin
      got.status         = status_o;
      got.bucket         = bucket_o;
      got.inserts        = insert_count_o;
      got.deletes        = delete_count_o;
      got.longest        = longest_chain_o;
      got.longest_bucket = longest_bucket_o;
      got.empty          = empty_buckets_o;
      got.single         = single_buckets_o;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, bucket", got.bucket, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.bucket !== want.bucket) report_mismatch("bucket", got.bucket, want.bucket);
        if (got.inserts !== want.inserts)
          report_mismatch("insert_count", got.inserts, want.inserts);
        if (got.deletes !== want.deletes)
          report_mismatch("delete_count", got.deletes, want.deletes);
        if (got.longest !== want.longest)
          report_mismatch("longest_chain", got.longest, want.longest);
        if (got.longest_bucket !== want.longest_bucket)
          report_mismatch("longest_bucket", got.longest_bucket, want.longest_bucket);
        if (got.empty !== want.empty) report_mismatch("empty_buckets", got.empty, want.empty);
        if (got.single !== want.single)
          report_mismatch("single_buckets", got.single, want.single);
      end
    end
  end

  // Count cycles without any transaction on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    kind_i       = KIND_INSERT;
    ip_address_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_WEIGHT_FOUR;
    cfg_data_i   = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    burst_left   = 0;
    hash_weight[REG_WEIGHT_FOUR]  = WEIGHT_FOUR_RST;
    hash_weight[REG_WEIGHT_THREE] = WEIGHT_THREE_RST;
    hash_weight[REG_WEIGHT_TWO]   = WEIGHT_TWO_RST;
    hash_weight[REG_WEIGHT_ONE]   = WEIGHT_ONE_RST;
    foreach (chain_len[i]) chain_len[i] = 0;
    insert_total = '0;
    delete_total = '0;
    peak_len     = 0;
    peak_bucket  = '0;
    empty_total  = BUCKETS;
    single_total = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_full_bucket();
    test_random_traffic();

    wait_until_drained();
    repeat (30) @(posedge clk_i);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/uht_pkg.sv
rtl/uht_hash.sv
rtl/uht_entry_ram.sv
rtl/ipv4_universal_hash_table_unit.sv
rtl/uht_checker.sv
sim/tb_ipv4_universal_hash_table_unit.sv
